// ===== rtl/core/ipv4hc_pkg.sv =====
// Shared types, constants and helper functions for the IPv4 header check block.
`default_nettype none
package ipv4hc_pkg;

   localparam int COUNT_BITS = 17;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [5:0] HDR_MIN = 6'd20;
   localparam logic [5:0] HDR_CSUM_END = 6'd60;
   localparam int EV_BITS = 25;

   localparam int EV_TRUNC = 0;
   localparam int EV_NOT_V4 = 1;
   localparam int EV_BAD_HLEN = 2;
   localparam int EV_OVER_CAP = 3;
   localparam int EV_UNDER_HDR = 4;
   localparam int EV_SAME_ADDR = 5;
   localparam int EV_SRC_BCAST = 6;
   localparam int EV_DST_BCAST = 7;
   localparam int EV_LOOPBACK = 8;
   localparam int EV_SRC_THIS = 9;
   localparam int EV_DST_THIS = 10;
   localparam int EV_SRC_MCAST = 11;
   localparam int EV_SRC_RSVD = 12;
   localparam int EV_DST_RSVD = 13;
   localparam int EV_OPT_LEN = 14;
   localparam int EV_OPT_TRUNC = 15;
   localparam int EV_FRAG_RSVD = 16;
   localparam int EV_DF_OFFSET = 17;
   localparam int EV_FRAG_OVER = 18;
   localparam int EV_FRAG_ZERO = 19;
   localparam int EV_MF_DF = 20;
   localparam int EV_OPT_DOS = 21;
   localparam int EV_OPTS = 22;
   localparam int EV_UNASSIGNED = 23;
   localparam int EV_CSUM = 24;

   localparam logic [7:0] OPT_EOL = 8'h00;
   localparam logic [7:0] OPT_NOP = 8'h01;
   localparam logic [7:0] OPT_RR = 8'h07;
   localparam logic [7:0] OPT_TS = 8'h44;
   localparam logic [7:0] OPT_RA = 8'h94;

   localparam logic [15:0] FO_RSVD = 16'h8000;
   localparam logic [15:0] FO_DF = 16'h4000;
   localparam logic [15:0] FO_MF = 16'h2000;
   localparam logic [15:0] FO_OFFSET = 16'h1FFF;

   localparam logic [1:0] CSR_CSUM_EN = 2'd0;
   localparam logic [1:0] CSR_ADDR_EN = 2'd1;
   localparam logic [1:0] CSR_PROTO_MIN = 2'd2;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_TRUNC = 3'd1,
      ST_NOT_V4 = 3'd2,
      ST_BAD_HLEN = 3'd3,
      ST_OVER_CAP = 3'd4,
      ST_UNDER_HDR = 3'd5,
      ST_BAD_CSUM = 3'd6
   } status_type;

   typedef struct packed {
      logic [5:0] inv_bytes;
      logic [2:0] oflags;
      logic       ev_opt_len;
      logic       ev_opt_trunc;
      logic       ev_dos;
      logic       ev_opts;
   } walk_result_type;

   localparam int MC_COUNT = 14;
   localparam logic [31:0] MC_NET [MC_COUNT] = '{
      32'hE0010000, 32'hE0050000, 32'hE0060000, 32'hE0080000, 32'hE0100000,
      32'hE0200000, 32'hE0400000, 32'hE0800000, 32'hE1000000, 32'hE2000000,
      32'hE4000000, 32'hEA000000, 32'hEC000000, 32'hEE000000
   };
   localparam logic [31:0] MC_MASK [MC_COUNT] = '{
      32'hFFFF0000, 32'hFFFF0000, 32'hFFFE0000, 32'hFFF80000, 32'hFFF00000,
      32'hFFE00000, 32'hFFC00000, 32'hFF800000, 32'hFF000000, 32'hFE000000,
      32'hFC000000, 32'hFE000000, 32'hFE000000, 32'hFF000000
   };

   function automatic logic mc_reserved(input logic [31:0] addr);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < MC_COUNT; i++) begin
         if ((addr & MC_MASK[i]) == MC_NET[i]) hit = 1'b1;
      end
      return hit;
   endfunction

   function automatic logic dos_check(input logic [7:0] code, input logic [7:0] len,
                                      input logic [7:0] ptr, input logic [7:0] flag);
      logic [2:0] rem;
      logic       hit;
      rem = len[2:0] + 3'd1 - ptr[2:0];
      hit = 1'b0;
      if (code == OPT_RR && len >= 8'd3 && ptr < len) begin
         hit = (rem[1:0] != 2'd0);
      end else if (code == OPT_TS && len >= 8'd2 && ptr < len) begin
         hit = (rem[1:0] != 2'd0) || (flag[0] && rem != 3'd0);
      end
      return hit;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ipv4hc_opt_walk.sv =====
// Option walker: follows the IPv4 option list one byte per word.
`default_nettype none
module ipv4hc_opt_walk
   import ipv4hc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step,
   input  wire logic            first,
   input  wire logic            pos_ok,
   input  wire logic [5:0]      pos,
   input  wire logic [7:0]      data,
   input  wire logic            last,
   input  wire logic [5:0]      hl,
   output walk_result_type      res
);

   logic [5:0] next_ff, next_in;
   logic       done_ff, done_in;
   logic       lpend_ff, lpend_in;
   logic       v1_ff, v1_in, v2_ff, v2_in;
   logic [7:0] h1_ff, h1_in, h2_ff, h2_in, h3_ff, h3_in;
   walk_result_type acc_ff, acc_in;

   logic [5:0] st_next;
   logic       st_done, st_lpend, st_v1, st_v2;
   logic [7:0] st_h1, st_h2, st_h3;
   walk_result_type st_acc;
   logic [5:0] opt_start;
   logic [8:0] opt_end;
   logic       valid_now;

   always_comb begin
      if (first) begin
         st_next = HDR_MIN;
         st_done = (hl <= HDR_MIN);
         st_lpend = 1'b0;
         st_v1 = 1'b0;
         st_v2 = 1'b0;
         st_h1 = 8'd0;
         st_h2 = 8'd0;
         st_h3 = 8'd0;
         st_acc = '0;
      end else begin
         st_next = next_ff;
         st_done = done_ff;
         st_lpend = lpend_ff;
         st_v1 = v1_ff;
         st_v2 = v2_ff;
         st_h1 = h1_ff;
         st_h2 = h2_ff;
         st_h3 = h3_ff;
         st_acc = acc_ff;
      end

      next_in = st_next;
      done_in = st_done;
      lpend_in = st_lpend;
      acc_in = st_acc;
      v1_in = st_v1;
      v2_in = st_v2;
      h1_in = st_h1;
      h2_in = st_h2;
      h3_in = st_h3;
      valid_now = 1'b0;
      opt_start = pos - 6'd1;
      opt_end = {3'd0, opt_start} + {1'b0, data};

      if (pos_ok) begin
         if (!st_done && !st_lpend && pos == st_next) begin
            if (data == OPT_EOL) begin
               done_in = 1'b1;
               acc_in.inv_bytes = hl - pos - 6'd1;
            end else if (data == OPT_NOP) begin
               acc_in.ev_opts = 1'b1;
               next_in = pos + 6'd1;
               done_in = (pos + 6'd1 == hl);
            end else begin
               if (data == OPT_RA) acc_in.oflags[1] = 1'b1;
               if (data == OPT_RR) acc_in.oflags[0] = 1'b1;
               if (pos + 6'd1 >= hl) begin
                  acc_in.ev_opt_trunc = 1'b1;
                  acc_in.inv_bytes = hl - pos;
                  done_in = 1'b1;
               end else begin
                  lpend_in = 1'b1;
               end
            end
         end else if (!st_done && st_lpend) begin
            lpend_in = 1'b0;
            if (data < 8'd2) begin
               acc_in.ev_opt_len = 1'b1;
               acc_in.inv_bytes = hl - opt_start;
               done_in = 1'b1;
            end else if (opt_end > {3'd0, hl}) begin
               acc_in.ev_opt_trunc = 1'b1;
               acc_in.inv_bytes = hl - opt_start;
               done_in = 1'b1;
            end else begin
               if (data == 8'd3) acc_in.oflags[2] = 1'b1;
               acc_in.ev_opts = 1'b1;
               next_in = opt_end[5:0];
               done_in = (opt_end[5:0] == hl);
               valid_now = 1'b1;
            end
         end

         if (st_v2 && dos_check(st_h3, st_h2, st_h1, data)) acc_in.ev_dos = 1'b1;
         if (last) begin
            if (valid_now && dos_check(st_h1, data, 8'd0, 8'd0)) acc_in.ev_dos = 1'b1;
            if (st_v1 && dos_check(st_h2, st_h1, data, 8'd0)) acc_in.ev_dos = 1'b1;
         end

         h1_in = data;
         h2_in = st_h1;
         h3_in = st_h2;
         v1_in = valid_now;
         v2_in = st_v1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff <= HDR_MIN;
         done_ff <= 1'b1;
         lpend_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         acc_ff <= '0;
      end else if (step) begin
         next_ff <= next_in;
         done_ff <= done_in;
         lpend_ff <= lpend_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         h1_ff <= h1_in;
         h2_ff <= h2_in;
         h3_ff <= h3_in;
      end
   end

   assign res = acc_ff;

endmodule
`default_nettype wire

// ===== rtl/core/ipv4hc_verdict.sv =====
// Verdict logic and result register.
`default_nettype none
module ipv4hc_verdict
   import ipv4hc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  pend,
   input  wire logic [COUNT_BITS-1:0] cap,
   input  wire logic [7:0]            hdr0,
   input  wire logic [15:0]           iplen,
   input  wire logic [15:0]           fo,
   input  wire logic [7:0]            proto,
   input  wire logic [31:0]           src,
   input  wire logic [31:0]           dst,
   input  wire logic [15:0]           csum,
   input  wire logic                  unsure,
   input  wire logic                  cooked,
   input  wire logic                  csum_en,
   input  wire logic                  addr_en,
   input  wire logic [7:0]            proto_min,
   input  wire walk_result_type       walk,
   input  wire logic                  rsp_stall,
   output logic                       rsp_valid,
   output logic [2:0]                 rsp_status,
   output logic [EV_BITS-1:0]         rsp_event_flags,
   output logic                       rsp_is_fragment,
   output logic                       rsp_more_fragments,
   output logic                       rsp_dont_fragment,
   output logic [7:0]                 rsp_next_protocol,
   output logic                       rsp_next_protocol_valid,
   output logic [5:0]                 rsp_header_length,
   output logic [5:0]                 rsp_invalid_option_bytes,
   output logic [2:0]                 rsp_option_flags
);

   logic                 valid_ff;
   status_type           status_ff, status_in;
   logic [EV_BITS-1:0]   ev_ff, ev_in;
   logic                 frag_ff, frag_in, mf_ff, mf_in, df_ff, df_in;
   logic [7:0]           proto_ff, proto_in;
   logic                 pvalid_ff, pvalid_in;
   logic [5:0]           hl_ff, hl_in, inv_ff, inv_in;
   logic [2:0]           oflags_ff, oflags_in;

   logic [5:0]  ihl4;
   logic [15:0] payload;
   logic [16:0] off_sum;
   logic [12:0] off;
   logic        load;

   assign load = !valid_ff || !rsp_stall;

   always_comb begin
      ihl4 = {hdr0[3:0], 2'b00};
      status_in = ST_OK;
      ev_in = '0;
      frag_in = 1'b0;
      mf_in = 1'b0;
      df_in = 1'b0;
      proto_in = 8'd0;
      pvalid_in = 1'b0;
      hl_in = 6'd0;
      inv_in = 6'd0;
      oflags_in = 3'd0;
      payload = iplen - {10'd0, ihl4};
      off = fo[12:0] & FO_OFFSET[12:0];
      off_sum = {4'd0, off} + {1'b0, payload};

      if (cap < COUNT_BITS'(HDR_MIN)) begin
         if (!unsure) ev_in[EV_TRUNC] = 1'b1;
         status_in = ST_TRUNC;
      end else if (hdr0[7:4] != 4'd4) begin
         if (!unsure) ev_in[EV_NOT_V4] = 1'b1;
         status_in = ST_NOT_V4;
      end else if (ihl4 < HDR_MIN) begin
         ev_in[EV_BAD_HLEN] = 1'b1;
         status_in = ST_BAD_HLEN;
      end else if (COUNT_BITS'(iplen) > cap) begin
         ev_in[EV_OVER_CAP] = 1'b1;
         status_in = ST_OVER_CAP;
      end else if (iplen < {10'd0, ihl4}) begin
         ev_in[EV_UNDER_HDR] = 1'b1;
         status_in = ST_UNDER_HDR;
      end else begin
         ev_in[EV_SAME_ADDR] = (src == dst);
         ev_in[EV_SRC_BCAST] = (src == 32'hFFFFFFFF);
         ev_in[EV_DST_BCAST] = (dst == 32'hFFFFFFFF);
         ev_in[EV_LOOPBACK] = (src[31:24] == 8'h7F) || (dst[31:24] == 8'h7F);
         ev_in[EV_SRC_THIS] = (src[31:24] == 8'h00);
         ev_in[EV_DST_THIS] = (dst[31:24] == 8'h00);
         ev_in[EV_SRC_MCAST] = (src[31:28] == 4'hE);
         if (addr_en) begin
            ev_in[EV_SRC_RSVD] = (src[31:28] == 4'hF) || mc_reserved(src);
            ev_in[EV_DST_RSVD] = (dst[31:28] == 4'hF) || mc_reserved(dst);
         end
         if (csum_en && csum != 16'hFFFF && !cooked) begin
            if (!unsure) ev_in[EV_CSUM] = 1'b1;
            status_in = ST_BAD_CSUM;
         end
      end

      if (status_in == ST_OK) begin
         hl_in = ihl4;
         inv_in = walk.inv_bytes;
         oflags_in = walk.oflags;
         ev_in[EV_OPT_LEN] = walk.ev_opt_len;
         ev_in[EV_OPT_TRUNC] = walk.ev_opt_trunc;
         ev_in[EV_OPT_DOS] = walk.ev_dos;
         ev_in[EV_OPTS] = walk.ev_opts;
         ev_in[EV_FRAG_RSVD] = (fo & FO_RSVD) != 16'd0;
         df_in = (fo & FO_DF) != 16'd0;
         mf_in = (fo & FO_MF) != 16'd0;
         ev_in[EV_DF_OFFSET] = df_in && (off != 13'd0);
         ev_in[EV_FRAG_OVER] = off_sum[16];
         frag_in = (off != 13'd0) || mf_in;
         ev_in[EV_FRAG_ZERO] = frag_in && (payload == 16'd0);
         ev_in[EV_MF_DF] = mf_in && df_in;
         proto_in = proto;
         if (!frag_in) begin
            if (proto >= proto_min) ev_in[EV_UNASSIGNED] = 1'b1;
            else pvalid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= pend;
      end
   end

   always_ff @(posedge clock) begin
      if (load && pend) begin
         status_ff <= status_in;
         ev_ff <= ev_in;
         frag_ff <= frag_in;
         mf_ff <= mf_in;
         df_ff <= df_in;
         proto_ff <= proto_in;
         pvalid_ff <= pvalid_in;
         hl_ff <= hl_in;
         inv_ff <= inv_in;
         oflags_ff <= oflags_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_status = status_ff;
   assign rsp_event_flags = ev_ff;
   assign rsp_is_fragment = frag_ff;
   assign rsp_more_fragments = mf_ff;
   assign rsp_dont_fragment = df_ff;
   assign rsp_next_protocol = proto_ff;
   assign rsp_next_protocol_valid = pvalid_ff;
   assign rsp_header_length = hl_ff;
   assign rsp_invalid_option_bytes = inv_ff;
   assign rsp_option_flags = oflags_ff;

endmodule
`default_nettype wire

// ===== rtl/core/ipv4_header_check_top.sv =====
// Top level of the IPv4 header check block.
//
// Packet bytes arrive on the req_ channel, one word per byte, starting at the
// first IPv4 header byte; req_last_byte marks the final captured byte. Each
// packet yields exactly one verdict word on the rsp_ channel; other bytes give
// none. A word is taken when valid is high and stall is low.
// Throughput: one byte per cycle across packets while req_stall is low.
// A verdict passes from its last byte through the input register and the
// header/option state update, then the verdict register.
// While a verdict waits under rsp_stall, bytes keep flowing until the next
// verdict needs the result register; then req_stall rises until it drains.
// Registers on the csr_ channel (index 0 checksum enable, 1 address checks,
// 2 lowest unassigned protocol) are always ready and should be written idle.
// Reset is synchronous: it empties the pipeline, restores the register
// defaults and starts a new packet with the next byte.
`default_nettype none
module ipv4_header_check_top
   import ipv4hc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_pkt_byte,
   input  wire logic                req_last_byte,
   input  wire logic                req_unsure_encap,
   input  wire logic                req_cooked_packet,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [2:0]               rsp_status,
   output logic [EV_BITS-1:0]       rsp_event_flags,
   output logic                     rsp_is_fragment,
   output logic                     rsp_more_fragments,
   output logic                     rsp_dont_fragment,
   output logic [7:0]               rsp_next_protocol,
   output logic                     rsp_next_protocol_valid,
   output logic [5:0]               rsp_header_length,
   output logic [5:0]               rsp_invalid_option_bytes,
   output logic [2:0]               rsp_option_flags,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [1:0]          csr_index,
   input  wire logic [7:0]          csr_wdata
);

   logic csum_en_ff, addr_en_ff;
   logic [7:0] proto_min_ff;

   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff, s1_unsure_ff, s1_cooked_ff;

   logic                  new_pkt_ff;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in, cnt_base;
   logic [15:0]           csum_ff, csum_in;
   logic [16:0]           csum_sum;
   logic [15:0]           csum_base;
   logic [7:0]            hdr0_ff, proto_ff;
   logic [15:0]           iplen_ff, fo_ff;
   logic [31:0]           src_ff, dst_ff;
   logic                  unsure_ff, cooked_ff;
   logic                  pend_ff;

   logic       advance, step, pos_ok;
   logic [5:0] pos, hl_cur;
   walk_result_type walk;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csum_en_ff <= 1'b1;
         addr_en_ff <= 1'b0;
         proto_min_ff <= 8'd143;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CSUM_EN: csum_en_ff <= csr_wdata[0];
            CSR_ADDR_EN: addr_en_ff <= csr_wdata[0];
            CSR_PROTO_MIN: proto_min_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign advance = !(pend_ff && rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign step = advance && s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         pend_ff <= s1_valid_ff && s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_byte_ff <= req_pkt_byte;
         s1_last_ff <= req_last_byte;
         s1_unsure_ff <= req_unsure_encap;
         s1_cooked_ff <= req_cooked_packet;
      end
   end

   always_comb begin
      cnt_base = new_pkt_ff ? '0 : cnt_ff;
      cnt_in = (cnt_base == COUNT_MAX) ? cnt_base : cnt_base + 1'b1;
      pos = cnt_base[5:0];
      pos_ok = (cnt_base[COUNT_BITS-1:6] == '0);
      hl_cur = new_pkt_ff ? {s1_byte_ff[3:0], 2'b00} : {hdr0_ff[3:0], 2'b00};
      csum_base = new_pkt_ff ? 16'd0 : csum_ff;
      csum_sum = {1'b0, csum_base} + (pos[0] ? {9'd0, s1_byte_ff} : {1'b0, s1_byte_ff, 8'd0});
      csum_in = csum_base;
      if (pos_ok && pos < HDR_CSUM_END && pos < hl_cur) begin
         csum_in = csum_sum[16] ? csum_sum[15:0] + 16'd1 : csum_sum[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         new_pkt_ff <= 1'b1;
         cnt_ff <= '0;
         csum_ff <= 16'd0;
      end else if (step) begin
         new_pkt_ff <= s1_last_ff;
         cnt_ff <= cnt_in;
         csum_ff <= csum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         if (new_pkt_ff) begin
            unsure_ff <= s1_unsure_ff;
            cooked_ff <= s1_cooked_ff;
         end
         if (pos_ok) begin
            case (pos)
               6'd0: hdr0_ff <= s1_byte_ff;
               6'd2: iplen_ff[15:8] <= s1_byte_ff;
               6'd3: iplen_ff[7:0] <= s1_byte_ff;
               6'd6: fo_ff[15:8] <= s1_byte_ff;
               6'd7: fo_ff[7:0] <= s1_byte_ff;
               6'd9: proto_ff <= s1_byte_ff;
               6'd12: src_ff[31:24] <= s1_byte_ff;
               6'd13: src_ff[23:16] <= s1_byte_ff;
               6'd14: src_ff[15:8] <= s1_byte_ff;
               6'd15: src_ff[7:0] <= s1_byte_ff;
               6'd16: dst_ff[31:24] <= s1_byte_ff;
               6'd17: dst_ff[23:16] <= s1_byte_ff;
               6'd18: dst_ff[15:8] <= s1_byte_ff;
               6'd19: dst_ff[7:0] <= s1_byte_ff;
               default: ;
            endcase
         end
      end
   end

   ipv4hc_opt_walk u_walk (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .first  (new_pkt_ff),
      .pos_ok (pos_ok),
      .pos    (pos),
      .data   (s1_byte_ff),
      .last   (s1_last_ff),
      .hl     (hl_cur),
      .res    (walk)
   );

   ipv4hc_verdict u_verdict (
      .clock                    (clock),
      .reset                    (reset),
      .pend                     (pend_ff),
      .cap                      (cnt_ff),
      .hdr0                     (hdr0_ff),
      .iplen                    (iplen_ff),
      .fo                       (fo_ff),
      .proto                    (proto_ff),
      .src                      (src_ff),
      .dst                      (dst_ff),
      .csum                     (csum_ff),
      .unsure                   (unsure_ff),
      .cooked                   (cooked_ff),
      .csum_en                  (csum_en_ff),
      .addr_en                  (addr_en_ff),
      .proto_min                (proto_min_ff),
      .walk                     (walk),
      .rsp_stall                (rsp_stall),
      .rsp_valid                (rsp_valid),
      .rsp_status               (rsp_status),
      .rsp_event_flags          (rsp_event_flags),
      .rsp_is_fragment          (rsp_is_fragment),
      .rsp_more_fragments       (rsp_more_fragments),
      .rsp_dont_fragment        (rsp_dont_fragment),
      .rsp_next_protocol        (rsp_next_protocol),
      .rsp_next_protocol_valid  (rsp_next_protocol_valid),
      .rsp_header_length        (rsp_header_length),
      .rsp_invalid_option_bytes (rsp_invalid_option_bytes),
      .rsp_option_flags         (rsp_option_flags)
   );

   a_block_on_full: assert property (@(posedge clock) disable iff (reset)
      pend_ff && rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while verdict blocked");

   a_drop_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_header_length == 6'd0 &&
      rsp_next_protocol == 8'd0 && rsp_invalid_option_bytes == 6'd0)
      else $error("dropped verdict carries fields");

   a_ok_hlen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK |-> rsp_header_length >= HDR_MIN &&
      rsp_invalid_option_bytes <= rsp_header_length - HDR_MIN)
      else $error("option cut count exceeds option area");

   a_pend_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(pend_ff) |-> $past(s1_last_ff))
      else $error("verdict raised without last byte");

endmodule
`default_nettype wire
